@@ rtl/spq_pkg.sv @@
// Shared types, codes and default sizes of the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;
  localparam int PRIO_BITS_DEF  = 8;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // operation broadcast to every cell for one request
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: a row of slot cells and the result register.
// Bounded priority queue built as a row of DEPTH slot cells, highest priority at the
// head; equal priorities leave in arrival order. Every request (enqueue or dequeue,
// chosen by in_tuser) is finished in the cycle it is accepted: all cells compare the
// new priority in parallel and every cell that moves shifts by one slot at once, so
// one request is taken per clock. The single result of each request sits in an
// output register, and a new request is taken whenever that register is empty or
// being drained in the same cycle. An enqueue to a full queue is rejected with the
// queue unchanged; a dequeue from an empty queue is flagged and returns zero.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int PRIO_BITS  = PRIO_BITS_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = ((VALUE_BITS + PRIO_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((VALUE_BITS + 2 + CNT_W + 1 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // item_value, item_priority
  input  logic             in_tuser,   // cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // out_value, status, entry_count, is_empty
);

  logic                  in_acc;
  logic                  cmd;
  logic [VALUE_BITS-1:0] item_value;
  logic [PRIO_BITS-1:0]  item_priority;
  spq_op_t               op;
  logic                  full, empty;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;
  spq_status_t           status;

  logic [DEPTH-1:0]      keep_w;
  logic [DEPTH-1:0]      valid_w;
  logic [VALUE_BITS-1:0] value_w [DEPTH];
  logic [PRIO_BITS-1:0]  prio_w  [DEPTH];

  assign in_tready     = !out_valid_r || out_tready;
  assign in_acc        = in_tvalid && in_tready;
  assign cmd           = in_tuser;
  assign item_value    = in_tdata[VALUE_BITS-1:0];
  assign item_priority = in_tdata[VALUE_BITS+PRIO_BITS-1:VALUE_BITS];

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign op.enq = in_acc && (cmd == CMD_ENQ) && !full;
  assign op.deq = in_acc && (cmd == CMD_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_keep, l_valid, r_valid;
    logic [VALUE_BITS-1:0] l_value, r_value;
    logic [PRIO_BITS-1:0]  l_prio, r_prio;

    if (i == 0) begin : g_head
      // head: nothing in front, so a non-kept head takes the new entry
      assign l_keep  = 1'b1;
      assign l_valid = 1'b1;
      assign l_value = item_value;
      assign l_prio  = item_priority;
    end else begin : g_mid
      assign l_keep  = keep_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_value = value_w[i-1];
      assign l_prio  = prio_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_prio  = '0;
    end else begin : g_body
      assign r_valid = valid_w[i+1];
      assign r_value = value_w[i+1];
      assign r_prio  = prio_w[i+1];
    end

    spq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .PRIO_BITS  (PRIO_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .new_value   (item_value),
      .new_prio    (item_priority),
      .left_keep   (l_keep),
      .left_valid  (l_valid),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_value (r_value),
      .right_prio  (r_prio),
      .keep        (keep_w[i]),
      .valid       (valid_w[i]),
      .value       (value_w[i]),
      .prio        (prio_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (op.enq) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.deq) begin
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd == CMD_ENQ) begin
      status = full ? ST_FULL : ST_DONE;
    end else begin
      status = empty ? ST_EMPTY : ST_DONE;
    end

    out_data_nxt = '0;
    if (op.deq) begin
      out_data_nxt[VALUE_BITS-1:0] = value_w[0];
    end
    out_data_nxt[VALUE_BITS+1:VALUE_BITS]             = status;
    out_data_nxt[VALUE_BITS+2+CNT_W-1:VALUE_BITS+2]   = count_nxt;
    out_data_nxt[VALUE_BITS+2+CNT_W]                  = (count_nxt == '0);

    // hold the result until taken; load a fresh one on every request
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_w) == int'(count_r))
    else $error("sorted_priority_queue: count disagrees with occupied slots");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_w & (valid_w + DEPTH'(1))) == '0)
    else $error("sorted_priority_queue: occupied slots not packed at head");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_ENQ) && full) |=> $stable(count_r) && $stable(valid_w))
    else $error("sorted_priority_queue: rejected enqueue changed the queue");
`endif

endmodule

@@ rtl/spq_cell.sv @@
// One slot of the sorted queue: holds an entry and shifts with its neighbours.
module spq_cell import spq_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int PRIO_BITS  = PRIO_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_op_t               op,
  input  logic [VALUE_BITS-1:0] new_value,
  input  logic [PRIO_BITS-1:0]  new_prio,
  input  logic                  left_keep,
  input  logic                  left_valid,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [PRIO_BITS-1:0]  left_prio,
  input  logic                  right_valid,
  input  logic [VALUE_BITS-1:0] right_value,
  input  logic [PRIO_BITS-1:0]  right_prio,
  output logic                  keep,
  output logic                  valid,
  output logic [VALUE_BITS-1:0] value,
  output logic [PRIO_BITS-1:0]  prio
);

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [PRIO_BITS-1:0]  prio_r, prio_nxt;

  // entries at or above the new priority stay put on an insert
  assign keep = valid_r && (prio_r >= new_prio);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (op.enq) begin
      valid_nxt = valid_r | left_valid;
      if (!keep) begin
        if (left_keep) begin
          value_nxt = new_value;
          prio_nxt  = new_prio;
        end else begin
          value_nxt = left_value;
          prio_nxt  = left_prio;
        end
      end
    end else if (op.deq) begin
      valid_nxt = right_valid;
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign valid = valid_r;
  assign value = value_r;
  assign prio  = prio_r;

`ifndef NO_ASSERTIONS
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && right_valid) |-> (prio_r >= right_prio))
    else $error("spq_cell: entry order broken");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of sorted_priority_queue: directed table of requests, then random traffic.
module tb_top import spq_pkg::*; ();

  localparam int CNT_W       = $clog2(DEPTH_DEF + 1);
  localparam int IN_W        = ((VALUE_BITS_DEF + PRIO_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W       = ((VALUE_BITS_DEF + 2 + CNT_W + 1 + 7) / 8) * 8;
  localparam int N_RANDOM    = 825;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int PAUSE_AT    = 500;

  typedef struct packed {
    logic [VALUE_BITS_DEF-1:0] value;
    spq_status_t               status;
    logic [CNT_W-1:0]          count;
    logic                      empty;
  } pq_result_t;

  typedef struct packed {
    logic                      cmd;
    logic [VALUE_BITS_DEF-1:0] value;
    logic [PRIO_BITS_DEF-1:0]  prio;
    logic                      typed;
    pq_result_t                want;
  } dir_row_t;

  // extremes, empty and full cases, ties among equal priorities
  localparam dir_row_t DIR_TAB [25] = '{
    '{CMD_DEQ, 32'hDEAD_BEEF, 8'h5A, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0, 1'b1}},
    '{CMD_ENQ, 32'h0000_0000, 8'h00, 1'b1, '{32'h0000_0000, ST_DONE, 5'd1, 1'b0}},
    '{CMD_ENQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0000_0000, ST_DONE, 5'd2, 1'b0}},
    '{CMD_DEQ, 32'h1357_9BDF, 8'hFF, 1'b1, '{32'hFFFF_FFFF, ST_DONE, 5'd1, 1'b0}},
    '{CMD_DEQ, 32'h0000_0000, 8'h00, 1'b1, '{32'h0000_0000, ST_DONE, 5'd0, 1'b1}},
    '{CMD_DEQ, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0, 1'b1}},
    '{CMD_ENQ, 32'hA000_0001, 8'h10, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0002, 8'h80, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0003, 8'h10, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0004, 8'hFF, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0005, 8'h00, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0006, 8'h80, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0007, 8'h10, 1'b0, '0},
    '{CMD_ENQ, 32'h5A5A_5A5A, 8'h7F, 1'b0, '0},
    '{CMD_ENQ, 32'hA5A5_A5A5, 8'h80, 1'b0, '0},
    '{CMD_ENQ, 32'h8000_0000, 8'h01, 1'b0, '0},
    '{CMD_ENQ, 32'h0000_0001, 8'hFE, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_000C, 8'h10, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_000D, 8'h00, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_000E, 8'hFF, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_000F, 8'h80, 1'b0, '0},
    '{CMD_ENQ, 32'hA000_0010, 8'h10, 1'b1, '{32'h0000_0000, ST_DONE, 5'd16, 1'b0}},
    '{CMD_ENQ, 32'h5555_AAAA, 8'hFF, 1'b1, '{32'h0000_0000, ST_FULL, 5'd16, 1'b0}},
    '{CMD_DEQ, 32'h0F0F_0F0F, 8'hF0, 1'b0, '0},
    '{CMD_ENQ, 32'hCAFE_F00D, 8'h80, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // shadow of the queue contents, head at slot 0
  logic [VALUE_BITS_DEF-1:0] slot_val  [DEPTH_DEF];
  logic [PRIO_BITS_DEF-1:0]  slot_prio [DEPTH_DEF];
  int                        fill = 0;

  pq_result_t pending_results [$];
  int n_errors  = 0;
  int n_enq     = 0;
  int n_deq     = 0;
  int n_full    = 0;
  int n_empty   = 0;
  int n_results = 0;
  int max_fill  = 0;
  int snd_mode  = 0;
  int rcv_mode  = 0;

  sorted_priority_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Apply one request to the shadow queue and return the result it should produce.
  function automatic pq_result_t pq_apply(input logic cmd, input logic [VALUE_BITS_DEF-1:0] value,
                                          input logic [PRIO_BITS_DEF-1:0] prio);
    pq_result_t r;
    int         pos;
    int         i;
    r = '{value: '0, status: ST_DONE, count: '0, empty: 1'b0};
    if (cmd == CMD_ENQ) begin
      if (fill == DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        // insert behind every entry of equal or higher priority
        pos = 0;
        while (pos < fill && slot_prio[pos] >= prio) pos++;
        for (i = fill; i > pos; i--) begin
          slot_val[i]  = slot_val[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_val[pos]  = value;
        slot_prio[pos] = prio;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = slot_val[0];
      for (i = 0; i < fill - 1; i++) begin
        slot_val[i]  = slot_val[i+1];
        slot_prio[i] = slot_prio[i+1];
      end
      fill--;
    end
    r.count = CNT_W'(fill);
    r.empty = (fill == 0);
    return r;
  endfunction

  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 19);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_req(input logic cmd, input logic [VALUE_BITS_DEF-1:0] value,
                          input logic [PRIO_BITS_DEF-1:0] prio, input logic typed,
                          input pq_result_t want, input bit drain);
    int         gap;
    pq_result_t r;
    gap = draw_gap(snd_mode);
    if (drain || gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        // hold until every outstanding result has come back
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {prio, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = pq_apply(cmd, value, prio);
    pending_results.push_back(typed ? want : r);
    if (cmd == CMD_ENQ) n_enq++;
    else n_deq++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (fill > max_fill) max_fill = fill;
  endtask

  initial begin
    logic                     cmd;
    logic [PRIO_BITS_DEF-1:0] prio;
    int                       enq_pct;
    enq_pct = 50;
    in_tvalid  <= 1'b0;
    in_tuser   <= CMD_ENQ;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    rst_n      <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    snd_mode = 1;
    foreach (DIR_TAB[i])
      send_req(DIR_TAB[i].cmd, DIR_TAB[i].value, DIR_TAB[i].prio, DIR_TAB[i].typed,
               DIR_TAB[i].want, 1'b0);

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 50 == 0) snd_mode = $urandom_range(0, 2);
      // drift between filling, balanced and draining phases to visit full and empty often
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 15;
        endcase
      end
      cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: prio = PRIO_BITS_DEF'($urandom_range(0, 3));
        5, 6:          prio = $urandom_range(0, 1) ? '1 : '0;
        default:       prio = PRIO_BITS_DEF'($urandom);
      endcase
      send_req(cmd, $urandom, prio, 1'b0, '0, k == PAUSE_AT);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d enqueues and %0d dequeues, %0d rejected as full, %0d on an empty queue",
             n_enq, n_deq, n_full, n_empty);
    $display("highest fill %0d of %0d, %0d results checked", max_fill, DEPTH_DEF, n_results);
    if (n_errors == 0) begin
      $display("sorted_priority_queue regression: pass");
    end else begin
      $display("sorted_priority_queue regression: fail");
    end
    $finish;
  end

  initial begin
    int                        gap;
    pq_result_t                want;
    logic [VALUE_BITS_DEF-1:0] got_value;
    logic [1:0]                got_status;
    logic [CNT_W-1:0]          got_count;
    logic                      got_empty;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n_results % 50 == 0) rcv_mode = $urandom_range(0, 2);
      // one long stall so the output register fills and the input backs up
      gap = (n_results == HOLD_AT) ? HOLD_CYCLES : draw_gap(rcv_mode);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got_value  = out_tdata[VALUE_BITS_DEF-1:0];
      got_status = out_tdata[VALUE_BITS_DEF +: 2];
      got_count  = out_tdata[VALUE_BITS_DEF+2 +: CNT_W];
      got_empty  = out_tdata[VALUE_BITS_DEF+2+CNT_W];
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %h status %0d count %0d empty %b",
                 $time, got_value, got_status, got_count, got_empty);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (got_value !== want.value) begin
          $display("%0t: out_value expected %h got %h", $time, want.value, got_value);
          n_errors++;
        end
        if (got_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got_status);
          n_errors++;
        end
        if (got_count !== want.count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, want.count, got_count);
          n_errors++;
        end
        if (got_empty !== want.empty) begin
          $display("%0t: is_empty expected %b got %b", $time, want.empty, got_empty);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("sorted_priority_queue regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/tb_top.sv
